// ===== rtl/core/earliest_event_deadline_tracker_core_assert.svh =====
// Assertion macros shared by the earliest event deadline tracker RTL.
`ifndef EARLIEST_EVENT_DEADLINE_TRACKER_CORE_ASSERT_SVH
`define EARLIEST_EVENT_DEADLINE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EEDT_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("eedt: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EEDT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("eedt: next-cycle check failed");

`endif

// ===== rtl/core/eedt_pkg.sv =====
// Shared types and codes of the earliest event deadline tracker.
package eedt_pkg;

  localparam int TIME_W  = 64;
  localparam int OP_W    = 2;
  localparam int SRC_W   = 3;
  localparam int ST_W    = 2;
  localparam int MASK_W  = 5;
  localparam int MAX_SLOTS = 1 << SRC_W;

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_SOURCE = 2'd1;
  localparam logic [ST_W-1:0] ST_LATE       = 2'd2;

  typedef struct packed {
    logic                 any;
    logic [TIME_W-1:0]    earliest;
    logic [MAX_SLOTS-1:0] ties;
  } summary_t;

endpackage

// ===== rtl/core/eedt_store.sv =====
// Deadline register file and armed mask with request decode and status.
module eedt_store
  import eedt_pkg::*;
#(
  parameter int SOURCE_COUNT = 5,
  parameter int SLOTS        = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         commit,
  input  logic [OP_W-1:0]              opcode,
  input  logic [SRC_W-1:0]             source,
  input  logic [TIME_W-1:0]            deadline,
  input  logic [TIME_W-1:0]            current_time,
  output logic [ST_W-1:0]              status,
  output logic [SLOTS-1:0][TIME_W-1:0] entries_next,
  output logic [MAX_SLOTS-1:0]         mask_next
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0][TIME_W-1:0] entries;
  logic [SLOTS-1:0]             mask;
  logic [SLOTS-1:0]             mask_upd;
  logic [IDX_W-1:0]             idx;
  logic                         in_range;
  logic                         do_set;
  logic                         do_clear;

  assign idx      = source[IDX_W-1:0];
  assign in_range = int'(source) < SOURCE_COUNT;

  always_comb begin
    status   = ST_OK;
    do_set   = 1'b0;
    do_clear = 1'b0;
    if (opcode == OP_SET || opcode == OP_CLEAR) begin
      if (!in_range) begin
        status = ST_BAD_SOURCE;
      end else if (opcode == OP_SET) begin
        if (deadline < current_time) begin
          status = ST_LATE;
        end else begin
          do_set = 1'b1;
        end
      end else begin
        do_clear = 1'b1;
      end
    end
  end

  always_comb begin
    entries_next = entries;
    mask_upd     = mask;
    for (int i = 0; i < SLOTS; i++) begin
      if (idx == IDX_W'(i)) begin
        if (do_set) begin
          entries_next[i] = deadline;
          mask_upd[i]     = 1'b1;
        end
        if (do_clear) begin
          mask_upd[i] = 1'b0;
        end
      end
    end
    mask_next = MAX_SLOTS'({{MAX_SLOTS{1'b0}}, mask_upd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (commit) begin
      mask <= mask_upd;
    end
  end

  // Entries carry no reset; a source is armed only after its entry is written.
  always_ff @(posedge clk) begin
    if (commit && do_set) begin
      entries <= entries_next;
    end
  end

endmodule

// ===== rtl/core/eedt_summary.sv =====
// Combinational compare tree: earliest armed deadline and its tie mask.
module eedt_summary
  import eedt_pkg::*;
#(
  parameter int SLOTS = 5
) (
  input  logic [SLOTS-1:0][TIME_W-1:0] entries,
  input  logic [MAX_SLOTS-1:0]         mask,
  output summary_t                     summary
);

  logic [MAX_SLOTS-1:0][TIME_W-1:0] leaf;
  logic [3:0][TIME_W-1:0]           l1_d;
  logic [3:0]                       l1_v;
  logic [1:0][TIME_W-1:0]           l2_d;
  logic [1:0]                       l2_v;
  logic [TIME_W-1:0]                best;

  always_comb begin
    leaf = '0;
    for (int i = 0; i < SLOTS; i++) begin
      leaf[i] = entries[i];
    end
  end

  // Three-level tree; an unarmed side never wins.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (mask[2*i] && (!mask[2*i+1] || leaf[2*i] <= leaf[2*i+1])) begin
        l1_d[i] = leaf[2*i];
      end else begin
        l1_d[i] = leaf[2*i+1];
      end
      l1_v[i] = mask[2*i] | mask[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      if (l1_v[2*i] && (!l1_v[2*i+1] || l1_d[2*i] <= l1_d[2*i+1])) begin
        l2_d[i] = l1_d[2*i];
      end else begin
        l2_d[i] = l1_d[2*i+1];
      end
      l2_v[i] = l1_v[2*i] | l1_v[2*i+1];
    end
    if (l2_v[0] && (!l2_v[1] || l2_d[0] <= l2_d[1])) begin
      best = l2_d[0];
    end else begin
      best = l2_d[1];
    end
  end

  always_comb begin
    summary.any      = |mask;
    summary.earliest = summary.any ? best : '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      summary.ties[i] = mask[i] && (leaf[i] == best);
    end
  end

endmodule

// ===== rtl/core/earliest_event_deadline_tracker_core.sv =====
// Top level of the earliest event deadline tracker core.

// The tracker keeps one 64-bit deadline per event source and a mask of
// armed sources. Each input beat is a set, clear or query request, and each
// one yields exactly one result beat carrying the status and a summary of
// the state after the request: whether any source is armed, the earliest
// armed deadline (zero when none), the armed sources tied at that deadline,
// and the armed mask. A set or clear naming a source at or above
// SOURCE_COUNT is refused with a bad-source status, and a set whose deadline
// lies before the supplied current time is refused with a late status; a
// refused request changes nothing, and opcode 3 behaves as a query. The core
// sustains one beat per clock cycle while the output accepts results: a
// request is captured in an input register, and from there the decode, the
// register-file update and an eight-leaf compare tree over the updated
// deadlines run in a single combinational pass into the result register.
// That single pass between the input register and the result register sets
// the rate. The two registers let a new beat enter while a finished result
// still waits on the output side. Reset clears the armed mask; the deadline
// entries need no clearing pass because an entry is only read once a set
// has written it.
module earliest_event_deadline_tracker_core
  import eedt_pkg::*;
#(
  parameter int SOURCE_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // source[2:0], deadline[66:3], current_time[130:67], zero fill above.
  input  logic [135:0] s_axis_tdata,
  // opcode[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // any_active[0], earliest[64:1], tie_mask[69:65], active_mask[74:70],
  // zero fill above.
  output logic [79:0] m_axis_tdata,
  // status[1:0].
  output logic [1:0]  m_axis_tuser
);

  `include "earliest_event_deadline_tracker_core_assert.svh"

  // Sources beyond the three-bit source field can never be addressed.
  localparam int SLOTS = (SOURCE_COUNT < MAX_SLOTS) ? SOURCE_COUNT : MAX_SLOTS;

  // Input register.
  logic              in_valid;
  logic [OP_W-1:0]   in_opcode;
  logic [SRC_W-1:0]  in_source;
  logic [TIME_W-1:0] in_deadline;
  logic [TIME_W-1:0] in_now;

  // Result register.
  logic                 out_valid;
  logic [ST_W-1:0]      out_status;
  summary_t             out_summary;
  logic [MAX_SLOTS-1:0] out_mask;

  logic                         advance;
  logic                         commit;
  logic [ST_W-1:0]              status;
  logic [SLOTS-1:0][TIME_W-1:0] entries_next;
  logic [MAX_SLOTS-1:0]         mask_next;
  summary_t                     summary;

  // The result register can take a new beat when empty or being drained.
  assign advance       = !out_valid || m_axis_tready;
  assign commit        = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode   <= s_axis_tuser;
      in_source   <= s_axis_tdata[2:0];
      in_deadline <= s_axis_tdata[66:3];
      in_now      <= s_axis_tdata[130:67];
    end
  end

  eedt_store #(
    .SOURCE_COUNT (SOURCE_COUNT),
    .SLOTS        (SLOTS)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .commit       (commit),
    .opcode       (in_opcode),
    .source       (in_source),
    .deadline     (in_deadline),
    .current_time (in_now),
    .status       (status),
    .entries_next (entries_next),
    .mask_next    (mask_next)
  );

  eedt_summary #(
    .SLOTS (SLOTS)
  ) u_summary (
    .entries (entries_next),
    .mask    (mask_next),
    .summary (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status  <= status;
      out_summary <= summary;
      out_mask    <= mask_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  // Masks are cut to the five reported bits; bits above SLOTS are zero.
  assign m_axis_tdata  = {5'b0,
                          out_mask[MASK_W-1:0],
                          out_summary.ties[MASK_W-1:0],
                          out_summary.earliest,
                          out_summary.any};

  // A committed request always leaves a result waiting in the next cycle.
  `EEDT_ASSERT_NEXT(a_commit_gives_result, commit, out_valid)
  // The armed flag agrees with the full armed mask.
  `EEDT_ASSERT_NOW(a_any_matches_mask, out_valid, out_summary.any == (out_mask != '0))
  // Only armed sources can be tied at the earliest deadline.
  `EEDT_ASSERT_NOW(a_ties_armed, out_valid, (out_summary.ties & ~out_mask) == '0)
  // With something armed, at least one source holds the earliest deadline.
  `EEDT_ASSERT_NOW(a_ties_present, out_valid && out_summary.any, out_summary.ties != '0)
  // With nothing armed, the summary is all zero.
  `EEDT_ASSERT_NOW(a_idle_zero, out_valid && !out_summary.any,
    out_summary.earliest == '0 && out_summary.ties == '0)

endmodule
